// ===== design/bavg_pkg.sv =====
`default_nettype none

package bavg_pkg;

  // Channel width of one color component
  localparam int unsigned CHANNEL_BITS = 8;
  // Bits in the quotient step counter of the divider
  localparam int unsigned STEP_BITS = $clog2(CHANNEL_BITS);

  // Configuration register indexes
  localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd1;

  // Configuration write data width (widest register)
  localparam int unsigned CFG_DATA_BITS = 11;
  localparam int unsigned CFG_BLOCK_BITS = 5;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_DIV,
    S_OUT
  } state_e;

  // Per-pixel tile position flags
  typedef struct packed {
    logic valid;   // pixel lies inside a whole tile
    logic first;   // top-left pixel of its tile
    logic last;    // bottom-right pixel of its tile
    logic eoi;     // tile is the last one of the shrunk image
  } pix_info_t;

endpackage

`default_nettype wire

// ===== design/bavg_ram.sv =====
`default_nettype none

module bavg_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/bavg_ctrl.sv =====
`default_nettype none

// Configuration registers and raster position tracking.
module bavg_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [1:0]                              cfg_index_i,
  input  wire logic [bavg_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  input  wire logic                                    advance_i,
  output bavg_pkg::pix_info_t                          info_o,
  output logic [$clog2(MAX_WIDTH)-1:0]                 addr_o,
  output logic [$clog2(MAX_BLOCK*MAX_BLOCK+1)-1:0]     area_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned BW = $clog2(MAX_BLOCK + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned AREA_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int unsigned PW = ((WW > BW) ? WW : BW) + 2;
  localparam int unsigned RST_B = (MAX_BLOCK < 2) ? 1 : 2;
  localparam int unsigned RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned CFG_BLOCK_BITS_L = bavg_pkg::CFG_BLOCK_BITS;

  logic [BW-1:0]     blk_q, blk_d;
  logic [WW-1:0]     wid_q, wid_d;
  logic [AREA_W-1:0] area_q, area_d;
  logic [WW-1:0]     col_q, col_d, tsc_q, tsc_d, row_q, row_d, tsr_q, tsr_d;
  logic [BW-1:0]     kc_q, kc_d, kr_q, kr_d;
  logic [AW-1:0]     tc_q, tc_d;

  logic [CFG_BLOCK_BITS_L-1:0] cfg_blk;
  logic [BW-1:0]     blk_new;
  logic [WW-1:0]     wid_new;
  logic              cfg_hit;
  logic [PW-1:0]     b_p, w_p, c_end, r_end;
  logic [WW:0]       col_inc, row_inc;
  logic [BW-1:0]     b_m1;

  // Clamp written values into their legal ranges
  always_comb begin
    cfg_blk = cfg_data_i[CFG_BLOCK_BITS_L-1:0];
    if (cfg_blk == '0) begin
      blk_new = BW'(1);
    end else if (32'(cfg_blk) > MAX_BLOCK) begin
      blk_new = BW'(MAX_BLOCK);
    end else begin
      blk_new = BW'(cfg_blk);
    end
    if (cfg_data_i == '0) begin
      wid_new = WW'(1);
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      wid_new = WW'(MAX_WIDTH);
    end else begin
      wid_new = WW'(cfg_data_i);
    end
  end

  // Register writes; any known register restarts the image
  always_comb begin
    blk_d   = blk_q;
    wid_d   = wid_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bavg_pkg::CFG_BLOCK_SIZE: begin
          blk_d   = blk_new;
          cfg_hit = 1'b1;
        end
        bavg_pkg::CFG_IMAGE_WIDTH: begin
          wid_d   = wid_new;
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    area_d = AREA_W'((2*BW)'(blk_d) * (2*BW)'(blk_d));
  end

  // Tile geometry of the current pixel
  always_comb begin
    b_p   = PW'(blk_q);
    w_p   = PW'(wid_q);
    c_end = PW'(tsc_q) + b_p;
    r_end = PW'(tsr_q) + b_p;
    b_m1  = blk_q - BW'(1);
    info_o.valid = (c_end <= w_p) && (r_end <= w_p);
    info_o.first = (kc_q == '0) && (kr_q == '0);
    info_o.last  = (kc_q == b_m1) && (kr_q == b_m1);
    info_o.eoi   = ((c_end + b_p) > w_p) && ((r_end + b_p) > w_p);
  end

  // Raster position advance
  always_comb begin
    col_d   = col_q;
    tsc_d   = tsc_q;
    kc_d    = kc_q;
    tc_d    = tc_q;
    row_d   = row_q;
    tsr_d   = tsr_q;
    kr_d    = kr_q;
    col_inc = {1'b0, col_q} + (WW+1)'(1);
    row_inc = {1'b0, row_q} + (WW+1)'(1);
    if (cfg_hit) begin
      col_d = '0; tsc_d = '0; kc_d = '0; tc_d = '0;
      row_d = '0; tsr_d = '0; kr_d = '0;
    end else if (advance_i) begin
      if (col_inc >= (WW+1)'(wid_q)) begin
        col_d = '0; tsc_d = '0; kc_d = '0; tc_d = '0;
        if (row_inc >= (WW+1)'(wid_q)) begin
          row_d = '0; tsr_d = '0; kr_d = '0;
        end else begin
          row_d = row_inc[WW-1:0];
          if (kr_q + BW'(1) == blk_q) begin
            kr_d  = '0;
            tsr_d = tsr_q + WW'(blk_q);
          end else begin
            kr_d = kr_q + BW'(1);
          end
        end
      end else begin
        col_d = col_inc[WW-1:0];
        if (kc_q + BW'(1) == blk_q) begin
          kc_d  = '0;
          tsc_d = tsc_q + WW'(blk_q);
          tc_d  = tc_q + AW'(1);
        end else begin
          kc_d = kc_q + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q  <= BW'(RST_B);
      wid_q  <= WW'(RST_W);
      area_q <= AREA_W'(RST_B * RST_B);
      col_q  <= '0;
      tsc_q  <= '0;
      kc_q   <= '0;
      tc_q   <= '0;
      row_q  <= '0;
      tsr_q  <= '0;
      kr_q   <= '0;
    end else begin
      blk_q  <= blk_d;
      wid_q  <= wid_d;
      area_q <= area_d;
      col_q  <= col_d;
      tsc_q  <= tsc_d;
      kc_q   <= kc_d;
      tc_q   <= tc_d;
      row_q  <= row_d;
      tsr_q  <= tsr_d;
      kr_q   <= kr_d;
    end
  end

  assign addr_o = tc_q;
  assign area_o = area_q;

endmodule

`default_nettype wire

// ===== design/bavg_div.sv =====
`default_nettype none

// Three-channel restoring divider, one quotient bit per cycle per channel.
module bavg_div #(
  parameter int unsigned SUM_W  = 16,
  parameter int unsigned AREA_W = 9
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     start_i,
  input  wire logic [SUM_W-1:0]                         sum_r_i,
  input  wire logic [SUM_W-1:0]                         sum_g_i,
  input  wire logic [SUM_W-1:0]                         sum_b_i,
  input  wire logic [AREA_W-1:0]                        area_i,
  output logic                                          done_o,
  output logic [3*bavg_pkg::CHANNEL_BITS-1:0]           quo_o
);

  localparam int unsigned Q  = bavg_pkg::CHANNEL_BITS;
  localparam int unsigned SB = bavg_pkg::STEP_BITS;

  logic [SUM_W-1:0]       rem_q [3];
  logic [SUM_W-1:0]       rem_d [3];
  logic [Q-1:0]           quo_q [3];
  logic [Q-1:0]           quo_d [3];
  logic [SB-1:0]          cnt_q, cnt_d;
  logic                   busy_q, busy_d, done_q, done_d;
  logic [SUM_W-1:0]       dvs;
  logic [SUM_W-1:0]       sum_in [3];

  assign sum_in[0] = sum_r_i;
  assign sum_in[1] = sum_g_i;
  assign sum_in[2] = sum_b_i;

  // Compare against the divisor shifted to the current quotient bit
  always_comb begin
    dvs    = SUM_W'(area_i) << cnt_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    for (int ch = 0; ch < 3; ch++) begin
      rem_d[ch] = rem_q[ch];
      quo_d[ch] = quo_q[ch];
    end
    if (start_i) begin
      cnt_d  = SB'(Q - 1);
      busy_d = 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
        rem_d[ch] = sum_in[ch];
        quo_d[ch] = '0;
      end
    end else if (busy_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_q[ch] >= dvs) begin
          rem_d[ch] = rem_q[ch] - dvs;
          quo_d[ch] = {quo_q[ch][Q-2:0], 1'b1};
        end else begin
          quo_d[ch] = {quo_q[ch][Q-2:0], 1'b0};
        end
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - SB'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      rem_q[ch] <= rem_d[ch];
      quo_q[ch] <= quo_d[ch];
    end
  end

  assign done_o = done_q;
  assign quo_o  = {quo_q[2], quo_q[1], quo_q[0]};

endmodule

`default_nettype wire

// ===== design/block_average_downscale.sv =====
// Channel       Direction  Handshake                Payload
// s_axis        in         s_axis_tvalid/tready     tdata: red, green, blue
// m_axis        out        m_axis_tvalid/tready     tdata: red, green, blue; tlast: end_of_image
// cfg           in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// A pixel that closes no tile: tile sum read from the row memory, then add and write
// back. A pixel that closes a tile then also goes through the 8 steps of the shared
// divider (one quotient bit per step), its registered done flag and the load of the
// output register. The output register lets the next pixels enter while a result
// waits; a second result stalls in the load state until the first is taken. No clearing
// pass after reset: the first pixel of each tile overwrites its memory entry.
`default_nettype none

module block_average_downscale #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [23:0]                         s_axis_tdata,  // red, green, blue
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [23:0]                              m_axis_tdata,  // red, green, blue
  output logic                                     m_axis_tlast,  // end_of_image
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [bavg_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int unsigned CB     = bavg_pkg::CHANNEL_BITS;
  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned AREA_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int unsigned SUM_W  = CB + $clog2(MAX_BLOCK * MAX_BLOCK);

  bavg_pkg::state_e    state_q, state_d;
  bavg_pkg::pix_info_t info, info_q;
  logic [AW-1:0]       addr, addr_q;
  logic [AREA_W-1:0]   area;
  logic [3*CB-1:0]     pix_q;
  logic                eoi_q, eoi_d;
  logic                pix_acc, cfg_we;
  logic [3*SUM_W-1:0]  rdata, wdata;
  logic [SUM_W-1:0]    sum_new [3];
  logic                we, div_start, div_done;
  logic [3*CB-1:0]     quo;
  logic                out_free, out_load;
  logic                ovalid_q, ovalid_d;
  logic [3*CB-1:0]     odata_q;
  logic                olast_q;

  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i;
  assign s_axis_tready = (state_q == bavg_pkg::S_IDLE);
  assign pix_acc       = s_axis_tvalid && s_axis_tready;

  bavg_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (pix_acc),
    .info_o      (info),
    .addr_o      (addr),
    .area_o      (area)
  );

  bavg_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .re_i    (pix_acc),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // Accumulate: first pixel of a tile replaces the stored sum
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (info_q.first) begin
        sum_new[ch] = SUM_W'(pix_q[ch*CB +: CB]);
      end else begin
        sum_new[ch] = rdata[ch*SUM_W +: SUM_W] + SUM_W'(pix_q[ch*CB +: CB]);
      end
    end
    wdata = {sum_new[2], sum_new[1], sum_new[0]};
  end

  bavg_div #(
    .SUM_W  (SUM_W),
    .AREA_W (AREA_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_r_i (sum_new[0]),
    .sum_g_i (sum_new[1]),
    .sum_b_i (sum_new[2]),
    .area_i  (area),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_free = !ovalid_q || m_axis_tready;

  // Sequencer: read, write back, divide, hand to output register
  always_comb begin
    state_d   = state_q;
    eoi_d     = eoi_q;
    we        = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      bavg_pkg::S_IDLE: begin
        if (pix_acc) begin
          state_d = bavg_pkg::S_RMW;
        end
      end
      bavg_pkg::S_RMW: begin
        we = info_q.valid;
        if (info_q.valid && info_q.last) begin
          div_start = 1'b1;
          eoi_d     = info_q.eoi;
          state_d   = bavg_pkg::S_DIV;
        end else begin
          state_d = bavg_pkg::S_IDLE;
        end
      end
      bavg_pkg::S_DIV: begin
        if (div_done) begin
          state_d = bavg_pkg::S_OUT;
        end
      end
      bavg_pkg::S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = bavg_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bavg_pkg::S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    ovalid_d = ovalid_q;
    if (out_load) begin
      ovalid_d = 1'b1;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bavg_pkg::S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    eoi_q <= eoi_d;
    if (pix_acc) begin
      pix_q  <= s_axis_tdata[3*CB-1:0];
      info_q <= info;
      addr_q <= addr;
    end
    if (out_load) begin
      odata_q <= quo;
      olast_q <= eoi_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = 24'(odata_q);
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire
